>>> rtl/core/wide_256bit_alu_assert.svh
// Assertion macros for the wide 256-bit ALU
`ifndef WIDE_256BIT_ALU_ASSERT_SVH
`define WIDE_256BIT_ALU_ASSERT_SVH
// implication checked every clock outside reset
`define W256_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the next clock
`define W256_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/core/w256_pkg.sv
// ----------------------------------------------------------------------------
// w256_pkg
// Shared types and operation codes for the wide 256-bit ALU.
// ----------------------------------------------------------------------------
package w256_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned DataW = 256;
  localparam int unsigned IterW = 9;

  typedef logic [DataW-1:0] data_t;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_MOD = 4'd4, OP_EXP = 4'd5, OP_LT = 4'd6, OP_GT = 4'd7,
    OP_EQ = 4'd8, OP_ISZERO = 4'd9, OP_AND = 4'd10, OP_OR = 4'd11,
    OP_XOR = 4'd12, OP_NOT = 4'd13, OP_SHL = 4'd14, OP_SHR = 4'd15
  } op_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_EXP_MUL, ST_EXP_SQR, ST_DONE
  } state_t;

  // control from the sequencer into the shared unit
  typedef struct packed {
    logic start;
    logic is_div;
  } unit_ctl_t;

endpackage

>>> rtl/core/wide_256bit_alu.sv
// ----------------------------------------------------------------------------
// wide_256bit_alu
// Stateless 256-bit ALU with wrapping arithmetic, built on one serial unit.
// ----------------------------------------------------------------------------
// Pulse start with an operation while busy is low; the result appears on
// r_w0..r_w3 for exactly one cycle with valid high and must be captured then.
// Logic, compare, add, sub and shift requests go straight to ST_DONE. mul,
// div and mod wait in ST_MUL or ST_DIV on the bit-serial shared unit (one
// bit per cycle). exp runs the same unit twice per exponent bit.
// Division or modulo by zero returns 0.

`include "wide_256bit_alu_assert.svh"

module wide_256bit_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        valid,
  input  logic [3:0]  req_type,
  input  logic [63:0] a_w0,
  input  logic [63:0] a_w1,
  input  logic [63:0] a_w2,
  input  logic [63:0] a_w3,
  input  logic [63:0] b_w0,
  input  logic [63:0] b_w1,
  input  logic [63:0] b_w2,
  input  logic [63:0] b_w3,
  output logic [63:0] r_w0,
  output logic [63:0] r_w1,
  output logic [63:0] r_w2,
  output logic [63:0] r_w3
);

  w256_pkg::state_t            state, state_next;
  w256_pkg::data_t             a, b, res, acc, cur, ux, uy, quick;
  w256_pkg::op_t               op;
  logic [w256_pkg::IterW-1:0]  ebit;
  w256_pkg::unit_ctl_t         uctl;
  logic                        udone;
  w256_pkg::data_t             uprod, uquo, urem;
  w256_pkg::data_t             ia, ib;
  logic                        big;

  assign ia = {a_w3, a_w2, a_w1, a_w0};
  assign ib = {b_w3, b_w2, b_w1, b_w0};
  assign big = (|ia[255:8]);

  // combinational results for the quick operations
  always_comb begin
    quick = '0;
    case (w256_pkg::op_t'(req_type))
      w256_pkg::OP_ADD:    quick = ia + ib;
      w256_pkg::OP_SUB:    quick = ia - ib;
      w256_pkg::OP_LT:     quick = {255'd0, ia < ib};
      w256_pkg::OP_GT:     quick = {255'd0, ia > ib};
      w256_pkg::OP_EQ:     quick = {255'd0, ia == ib};
      w256_pkg::OP_ISZERO: quick = {255'd0, ia == '0};
      w256_pkg::OP_AND:    quick = ia & ib;
      w256_pkg::OP_OR:     quick = ia | ib;
      w256_pkg::OP_XOR:    quick = ia ^ ib;
      w256_pkg::OP_NOT:    quick = ~ia;
      w256_pkg::OP_SHL:    quick = big ? '0 : ib << ia[7:0];
      w256_pkg::OP_SHR:    quick = big ? '0 : ib >> ia[7:0];
      default:             quick = '0;
    endcase
  end

  w256_serial_unit u_unit (
    .clk(clk), .rst(rst), .ctl(uctl), .x(ux), .y(uy),
    .done(udone), .prod(uprod), .quo(uquo), .rem(urem)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= w256_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // next state and unit launch
  always_comb begin
    state_next  = state;
    uctl.start  = 1'b0;
    uctl.is_div = 1'b0;
    ux          = a;
    uy          = b;
    unique case (state)
      w256_pkg::ST_IDLE: begin
        if (start) begin
          unique case (w256_pkg::op_t'(req_type))
            w256_pkg::OP_MUL: begin
              state_next = w256_pkg::ST_MUL;
              uctl.start = 1'b1; ux = ia; uy = ib;
            end
            w256_pkg::OP_DIV, w256_pkg::OP_MOD: begin
              state_next  = w256_pkg::ST_DIV;
              uctl.start  = 1'b1; uctl.is_div = 1'b1; ux = ia; uy = ib;
            end
            w256_pkg::OP_EXP: begin
              state_next = w256_pkg::ST_EXP_MUL;
              uctl.start = 1'b1; ux = 256'd1; uy = ia;
            end
            default: state_next = w256_pkg::ST_DONE;
          endcase
        end
      end
      w256_pkg::ST_MUL, w256_pkg::ST_DIV:
        if (udone) state_next = w256_pkg::ST_DONE;
      w256_pkg::ST_EXP_MUL:
        if (udone) begin
          state_next = w256_pkg::ST_EXP_SQR;
          uctl.start = 1'b1; ux = cur; uy = cur;
        end
      w256_pkg::ST_EXP_SQR:
        if (udone) begin
          if (ebit == w256_pkg::IterW'(w256_pkg::DataW - 1)) begin
            state_next = w256_pkg::ST_DONE;
          end else begin
            // the fresh square is on the unit output, cur updates this edge
            state_next = w256_pkg::ST_EXP_MUL;
            uctl.start = 1'b1; ux = acc; uy = uprod;
          end
        end
      w256_pkg::ST_DONE: state_next = w256_pkg::ST_IDLE;
      default:           state_next = w256_pkg::ST_IDLE;
    endcase
  end

  // request capture and result bookkeeping
  always_ff @(posedge clk) begin
    if (state == w256_pkg::ST_IDLE && start) begin
      op   <= w256_pkg::op_t'(req_type);
      a    <= ia;
      b    <= ib;
      res  <= quick;
      acc  <= 256'd1;
      cur  <= ia;
      ebit <= '0;
    end else if (udone) begin
      unique case (state)
        w256_pkg::ST_MUL: res <= uprod;
        w256_pkg::ST_DIV: res <= (b == '0) ? '0 :
                                 (op == w256_pkg::OP_DIV) ? uquo : urem;
        w256_pkg::ST_EXP_MUL: if (b[ebit[7:0]]) acc <= uprod;
        w256_pkg::ST_EXP_SQR: begin
          cur  <= uprod;
          ebit <= ebit + 1'b1;
          res  <= acc;
        end
        default: ;
      endcase
    end
  end

  assign busy  = (state != w256_pkg::ST_IDLE);
  assign valid = (state == w256_pkg::ST_DONE);
  assign {r_w3, r_w2, r_w1, r_w0} = res;

  `W256_ASSERT_NEXT(a_valid_once, clk, rst, valid, !valid, "result shown twice")
  `W256_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "request not taken")
  `W256_ASSERT_IMP(a_unit_idle, clk, rst, udone, state != w256_pkg::ST_IDLE,
                   "unit finished while idle")

endmodule

>>> rtl/core/w256_serial_unit.sv
// ----------------------------------------------------------------------------
// w256_serial_unit
// Shared bit-serial shift-add multiplier and restoring divider, 256 steps.
// ----------------------------------------------------------------------------
`include "wide_256bit_alu_assert.svh"

module w256_serial_unit (
  input  logic               clk,
  input  logic               rst,
  input  w256_pkg::unit_ctl_t ctl,
  input  w256_pkg::data_t    x,
  input  w256_pkg::data_t    y,
  output logic               done,
  output w256_pkg::data_t    prod,
  output w256_pkg::data_t    quo,
  output w256_pkg::data_t    rem
);

  logic                          running;
  logic                          is_div;
  logic [w256_pkg::IterW-1:0]    count;
  w256_pkg::data_t               acc;
  w256_pkg::data_t               mcand;
  w256_pkg::data_t               sh;
  w256_pkg::data_t               divr;

  logic [w256_pkg::DataW:0]      rr_shift;
  logic [w256_pkg::DataW:0]      diff;

  // one divider step: shift remainder, trial subtract
  assign rr_shift = {acc, sh[w256_pkg::DataW-1]};
  assign diff     = rr_shift - {1'b0, divr};

  // one step per cycle; mul shifts multiplier right and adds
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        count <= count + 1'b1;
        if (count == w256_pkg::IterW'(w256_pkg::DataW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      is_div <= ctl.is_div;
      acc    <= '0;
      mcand  <= x;
      sh     <= ctl.is_div ? x : y;
      divr   <= y;
    end else if (running) begin
      if (is_div) begin
        if (!diff[w256_pkg::DataW]) begin
          acc <= diff[w256_pkg::DataW-1:0];
          sh  <= {sh[w256_pkg::DataW-2:0], 1'b1};
        end else begin
          acc <= rr_shift[w256_pkg::DataW-1:0];
          sh  <= {sh[w256_pkg::DataW-2:0], 1'b0};
        end
      end else begin
        if (sh[0]) acc <= acc + mcand;
        mcand <= {mcand[w256_pkg::DataW-2:0], 1'b0};
        sh    <= {1'b0, sh[w256_pkg::DataW-1:1]};
      end
    end
  end

  assign prod = acc;
  assign quo  = sh;
  assign rem  = acc;

  `W256_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "done held two cycles")
  `W256_ASSERT_IMP(a_done_idle, clk, rst, done, !running, "done while running")
  `W256_ASSERT_NEXT(a_start_runs, clk, rst, ctl.start, running && count == '0,
                    "start did not launch")

endmodule

>>> tb/sv/tb_wide_256bit_alu.sv
// ----------------------------------------------------------------------------
// tb_wide_256bit_alu
// Self-checking bench for the 256-bit ALU: directed corner requests, then
// random requests with random gaps. A scoreboard predicts every result.
// ----------------------------------------------------------------------------
module tb_wide_256bit_alu;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandReqs  = 750;
  localparam int unsigned MaxExp    = 2;
  localparam longint     CycleLimit = 4000000;

  // Expected-result store with its own 256-bit predictor
  class alu_scoreboard;
    w256_pkg::data_t pending[$];

    function w256_pkg::data_t compute(w256_pkg::op_t op, w256_pkg::data_t a,
                                      w256_pkg::data_t b);
      w256_pkg::data_t acc;
      w256_pkg::data_t cur;
      acc = '0;
      case (op)
        w256_pkg::OP_ADD: acc = a + b;
        w256_pkg::OP_SUB: acc = a - b;
        w256_pkg::OP_MUL: acc = a * b;
        w256_pkg::OP_DIV: acc = (b == '0) ? '0 : a / b;
        w256_pkg::OP_MOD: acc = (b == '0) ? '0 : a % b;
        w256_pkg::OP_EXP: begin
          acc = w256_pkg::data_t'(1);
          cur = a;
          for (int i = 0; i < 256; i++) begin
            if (b[i]) acc = acc * cur;
            cur = cur * cur;
          end
        end
        w256_pkg::OP_LT: acc = w256_pkg::data_t'(a < b);
        w256_pkg::OP_GT: acc = w256_pkg::data_t'(a > b);
        w256_pkg::OP_EQ: acc = w256_pkg::data_t'(a == b);
        w256_pkg::OP_ISZERO: acc = w256_pkg::data_t'(a == '0);
        w256_pkg::OP_AND: acc = a & b;
        w256_pkg::OP_OR: acc = a | b;
        w256_pkg::OP_XOR: acc = a ^ b;
        w256_pkg::OP_NOT: acc = ~a;
        w256_pkg::OP_SHL: acc = (a >= 256) ? '0 : b << a[7:0];
        w256_pkg::OP_SHR: acc = (a >= 256) ? '0 : b >> a[7:0];
        default: acc = '0;
      endcase
      return acc;
    endfunction

    // record an accepted request
    function void note(w256_pkg::op_t op, w256_pkg::data_t a, w256_pkg::data_t b);
      pending = {pending, compute(op, a, b)};
    endfunction

    // compare one result with the oldest expectation; 0 if none waits
    function bit check(w256_pkg::data_t r, output w256_pkg::data_t e,
                       output logic [3:0] bad);
      bad = '0;
      e = '0;
      if (pending.size() == 0) return 0;
      e = pending.pop_front();
      for (int w = 0; w < 4; w++)
        bad[w] = (r[w*64 +: 64] !== e[w*64 +: 64]);
      return 1;
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic [3:0]      req_type = '0;
  w256_pkg::data_t a_val = '0;
  w256_pkg::data_t b_val = '0;
  logic            busy;
  logic            valid;
  logic [63:0]     r_w0, r_w1, r_w2, r_w3;

  alu_scoreboard results = new();
  int unsigned   errors = 0;
  int unsigned   exp_count = 0;
  longint        cycles = 0;

  wide_256bit_alu i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .valid(valid),
    .req_type(req_type),
    .a_w0(a_val[63:0]), .a_w1(a_val[127:64]), .a_w2(a_val[191:128]),
    .a_w3(a_val[255:192]),
    .b_w0(b_val[63:0]), .b_w1(b_val[127:64]), .b_w2(b_val[191:128]),
    .b_w3(b_val[255:192]),
    .r_w0(r_w0), .r_w1(r_w1), .r_w2(r_w2), .r_w3(r_w3)
  );

  always #5 clk = ~clk;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // run-time guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    w256_pkg::data_t got;
    w256_pkg::data_t want;
    logic [3:0]      bad;
    got = {r_w3, r_w2, r_w1, r_w0};
    if (!rst && valid) begin
      if (!results.check(got, want, bad))
        report($sformatf("unexpected result %h", got));
      else
        for (int w = 0; w < 4; w++)
          if (bad[w])
            report($sformatf("r_w%0d got %h want %h", w, got[w*64 +: 64],
                             want[w*64 +: 64]));
    end
  end

  function automatic logic [63:0] rand_word();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 5) return {$urandom(), $urandom()};
    if (k < 7) return '0;
    if (k < 8) return '1;
    return 64'($urandom_range(0, 15));
  endfunction

  function automatic w256_pkg::data_t rand_val();
    return {rand_word(), rand_word(), rand_word(), rand_word()};
  endfunction

  // idle cycles between requests: mostly short, a few long
  function automatic int unsigned gap_len();
    int unsigned k;
    k = $urandom_range(0, 19);
    if (k < 10) return 0;
    if (k < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // issue one request and hold it until accepted
  task automatic send(input w256_pkg::op_t op, input w256_pkg::data_t a,
                      input w256_pkg::data_t b);
    int unsigned idle;
    @(negedge clk);
    start    <= 1'b1;
    req_type <= op;
    a_val    <= a;
    b_val    <= b;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    results.note(op, a, b);
    if (op == w256_pkg::OP_EXP) exp_count++;
    idle = gap_len();
    if (idle != 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (idle - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (results.outstanding() != 0) @(negedge clk);
  endtask

  task automatic random_request();
    w256_pkg::op_t   op;
    w256_pkg::data_t a;
    w256_pkg::data_t b;
    op = w256_pkg::op_t'($urandom_range(0, 15));
    while (op == w256_pkg::OP_EXP && exp_count >= MaxExp)
      op = w256_pkg::op_t'($urandom_range(0, 15));
    a = rand_val();
    b = rand_val();
    case (op)
      w256_pkg::OP_SHL, w256_pkg::OP_SHR:
        if ($urandom_range(0, 9) < 7) a = w256_pkg::data_t'($urandom_range(0, 300));
      w256_pkg::OP_DIV, w256_pkg::OP_MOD:
        if ($urandom_range(0, 3) == 0) b = w256_pkg::data_t'({$urandom(), $urandom()});
      w256_pkg::OP_EQ, w256_pkg::OP_LT, w256_pkg::OP_GT:
        if ($urandom_range(0, 2) == 0) b = a;
      default: ;
    endcase
    send(op, a, b);
  endtask

  localparam w256_pkg::data_t Ones = '1;
  localparam w256_pkg::data_t Zero = '0;
  localparam w256_pkg::data_t One  = w256_pkg::data_t'(1);
  localparam w256_pkg::data_t Top  = w256_pkg::data_t'(1) << 255;

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners
    send(w256_pkg::OP_ADD, Ones, One);
    send(w256_pkg::OP_SUB, Zero, One);
    send(w256_pkg::OP_MUL, Ones, Ones);
    send(w256_pkg::OP_DIV, rand_val(), Zero);
    send(w256_pkg::OP_MOD, rand_val(), Zero);
    send(w256_pkg::OP_DIV, Ones, One);
    send(w256_pkg::OP_MOD, Ones, w256_pkg::data_t'(64'hFFFF_FFFF_FFFF_FFFF));
    send(w256_pkg::OP_EXP, Zero, Zero);
    send(w256_pkg::OP_EXP, rand_val(), rand_val());
    send(w256_pkg::OP_LT, Top, Top - One);
    send(w256_pkg::OP_GT, Top, Top - One);
    send(w256_pkg::OP_EQ, Ones, Ones);
    send(w256_pkg::OP_ISZERO, Zero, Ones);
    send(w256_pkg::OP_ISZERO, Top, Zero);
    send(w256_pkg::OP_AND, Ones, rand_val());
    send(w256_pkg::OP_OR, Zero, rand_val());
    send(w256_pkg::OP_XOR, Ones, Ones);
    send(w256_pkg::OP_NOT, Zero, Ones);
    send(w256_pkg::OP_SHL, Zero, Ones);
    send(w256_pkg::OP_SHL, w256_pkg::data_t'(255), Ones);
    send(w256_pkg::OP_SHL, w256_pkg::data_t'(256), Ones);
    send(w256_pkg::OP_SHR, w256_pkg::data_t'(1) << 64, Ones);
    send(w256_pkg::OP_SHR, w256_pkg::data_t'(255), Ones);
    send(w256_pkg::OP_SHR, w256_pkg::data_t'(256), Ones);
    drain();

    // random traffic, with a full drain midway
    for (int n = 0; n < RandReqs; n++) begin
      random_request();
      if (n == RandReqs / 2) drain();
    end
    drain();
    repeat (20) @(posedge clk);

    if (errors == 0 && results.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
